@@ src/falling_sand_cell_update_assert.svh @@
// ---------------------------------------------------------------------------
// Falling-sand cell update: assertion macros
// Concurrent assertion wrappers used by the RTL that checks itself.
// ---------------------------------------------------------------------------
`ifndef FALLING_SAND_CELL_UPDATE_ASSERT_SVH
`define FALLING_SAND_CELL_UPDATE_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define FSC_ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define FSC_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ src/fsc_pkg.sv @@
// ---------------------------------------------------------------------------
// Falling-sand cell update: package
// Cell kinds, command and move codes, sequencer states and shared helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

  localparam int DEF_MAX_COLS = 256;
  localparam int DEF_MAX_ROWS = 256;

  localparam int CFG_W = 9;
  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 9'd200;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [1:0] KIND_AIR   = 2'd0;
  localparam logic [1:0] KIND_SAND  = 2'd1;
  localparam logic [1:0] KIND_WATER = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;

  localparam logic [2:0] MOVE_NONE       = 3'd0;
  localparam logic [2:0] MOVE_DOWN       = 3'd1;
  localparam logic [2:0] MOVE_DOWN_LEFT  = 3'd2;
  localparam logic [2:0] MOVE_DOWN_RIGHT = 3'd3;
  localparam logic [2:0] MOVE_LEFT       = 3'd4;
  localparam logic [2:0] MOVE_RIGHT      = 3'd5;

  localparam logic [2:0] CAND_LAST_SAND  = 3'd2;
  localparam logic [2:0] CAND_LAST_WATER = 3'd4;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_SRC,
    ST_PROBE,
    ST_TEST,
    ST_VACATE
  } fsc_state_t;

  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

  // Move tried for a given candidate slot: down, two diagonals, two sides.
  function automatic logic [2:0] cand_move(logic [2:0] idx, logic diag_left,
                                           logic side_left);
    logic [2:0] m;
    unique case (idx)
      3'd0: m = MOVE_DOWN;
      3'd1: m = diag_left ? MOVE_DOWN_LEFT : MOVE_DOWN_RIGHT;
      3'd2: m = diag_left ? MOVE_DOWN_RIGHT : MOVE_DOWN_LEFT;
      3'd3: m = side_left ? MOVE_LEFT : MOVE_RIGHT;
      3'd4: m = side_left ? MOVE_RIGHT : MOVE_LEFT;
      default: m = MOVE_NONE;
    endcase
    return m;
  endfunction

  function automatic logic is_grain(logic [1:0] k);
    return (k == KIND_SAND) || (k == KIND_WATER);
  endfunction

endpackage

`default_nettype wire

@@ src/fsc_grid_mem.sv @@
// ---------------------------------------------------------------------------
// Falling-sand cell update: grid memory
// Single-port synchronous RAM of 2-bit cells with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module fsc_grid_mem import fsc_pkg::*; #(
  parameter int DEPTH  = DEF_MAX_COLS * DEF_MAX_ROWS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire mem_ctl_t          ctl,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [1:0]        wdata,
  output logic      [1:0]        rdata
);

  logic [1:0] cells [DEPTH];

  // Read-first: a write returns the old contents, which the sequencer never uses.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        cells[addr] <= wdata;
      end
      rdata <= cells[addr];
    end
  end

endmodule

`default_nettype wire

@@ src/fsc_ctrl.sv @@
// ---------------------------------------------------------------------------
// Falling-sand cell update: command sequencer
// Clears the grid after reset, then runs read, write and update commands
// against the grid memory one access per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "falling_sand_cell_update_assert.svh"

module fsc_ctrl import fsc_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int DEPTH    = MAX_COLS * MAX_ROWS,
  parameter int ADDR_W   = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [1:0]        cmd,
  input  wire logic [7:0]        col,
  input  wire logic [7:0]        row,
  input  wire logic [1:0]        kind_in,
  input  wire logic              rand_diag,
  input  wire logic              rand_side,
  input  wire logic [CFG_W-1:0]  grid_width,
  input  wire logic [CFG_W-1:0]  grid_height,
  output logic                   busy,
  output logic                   done,
  output logic      [1:0]        kind_out,
  output logic      [2:0]        move_done,
  output mem_ctl_t               mem_ctl,
  output logic      [ADDR_W-1:0] mem_addr,
  output logic      [1:0]        mem_wdata,
  input  wire logic [1:0]        mem_rdata
);

  localparam logic [ADDR_W-1:0] WIPE_LAST = ADDR_W'(DEPTH - 1);

  fsc_state_t        state, state_next;
  logic [ADDR_W-1:0] wipe_addr;
  logic [1:0]        cmd_q;
  logic [7:0]        col_q, row_q;
  logic [1:0]        kind_in_q;
  logic              diag_q, side_q;
  logic [1:0]        kind_q;
  logic [2:0]        cand_idx;
  logic [2:0]        move_q;

  logic              src_ok, below_ok, tgt_ok, last_cand, need_left;
  logic [8:0]        row_dn, tc, tr;
  logic [2:0]        cand_m;
  logic [ADDR_W-1:0] src_addr, tgt_addr;
  logic              finish, cand_step;
  logic [1:0]        fin_kind;
  logic [2:0]        fin_move;

  function automatic logic [ADDR_W-1:0] addr_of(logic [8:0] c, logic [8:0] r);
    return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

  assign busy = (state != ST_IDLE);

  assign row_dn   = {1'b0, row_q} + 9'd1;
  assign src_ok   = ({1'b0, col_q} < grid_width) && (32'(col_q) < MAX_COLS) &&
                    ({1'b0, row_q} < grid_height) && (32'(row_q) < MAX_ROWS);
  assign below_ok = (row_dn < grid_height) && (32'(row_dn) < MAX_ROWS);
  assign src_addr = addr_of({1'b0, col_q}, {1'b0, row_q});
  assign cand_m   = cand_move(cand_idx, diag_q, side_q);
  assign last_cand = (cand_idx == ((kind_q == KIND_WATER) ? CAND_LAST_WATER
                                                          : CAND_LAST_SAND));

  // Target cell of the candidate move and whether it lies inside the grid.
  always_comb begin
    tc        = {1'b0, col_q};
    tr        = {1'b0, row_q};
    need_left = 1'b0;
    unique case (cand_m)
      MOVE_DOWN: begin
        tr = row_dn;
      end
      MOVE_DOWN_LEFT: begin
        tr        = row_dn;
        tc        = {1'b0, col_q} - 9'd1;
        need_left = 1'b1;
      end
      MOVE_DOWN_RIGHT: begin
        tr = row_dn;
        tc = {1'b0, col_q} + 9'd1;
      end
      MOVE_LEFT: begin
        tc        = {1'b0, col_q} - 9'd1;
        need_left = 1'b1;
      end
      MOVE_RIGHT: begin
        tc = {1'b0, col_q} + 9'd1;
      end
      default: begin
        tr = {1'b0, row_q};
      end
    endcase
  end

  assign tgt_ok   = !(need_left && (col_q == 8'd0)) &&
                    (tc < grid_width) && (32'(tc) < MAX_COLS) &&
                    (tr < grid_height) && (32'(tr) < MAX_ROWS);
  assign tgt_addr = addr_of(tc, tr);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_WIPE: begin
        if (wipe_addr == WIPE_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_SRC;
      end
      ST_SRC: begin
        if (src_ok && (cmd_q == CMD_UPDATE) && is_grain(mem_rdata) && below_ok) begin
          state_next = ST_PROBE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PROBE: begin
        if (tgt_ok) begin
          state_next = ST_TEST;
        end else if (last_cand) begin
          state_next = ST_IDLE;
        end
      end
      ST_TEST: begin
        if (mem_rdata == KIND_AIR) begin
          state_next = ST_VACATE;
        end else if (last_cand) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_PROBE;
        end
      end
      ST_VACATE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_ctl   = '0;
    mem_addr  = src_addr;
    mem_wdata = KIND_AIR;
    finish    = 1'b0;
    fin_kind  = kind_q;
    fin_move  = MOVE_NONE;
    cand_step = 1'b0;
    unique case (state)
      ST_WIPE: begin
        mem_ctl  = '{en: 1'b1, we: 1'b1};
        mem_addr = wipe_addr;
      end
      ST_IDLE: begin
        mem_ctl.en = start;
        mem_addr   = addr_of({1'b0, col}, {1'b0, row});
      end
      ST_SRC: begin
        fin_kind = src_ok ? mem_rdata : KIND_AIR;
        finish   = (state_next == ST_IDLE);
        if (src_ok && (cmd_q == CMD_WRITE)) begin
          mem_ctl   = '{en: 1'b1, we: 1'b1};
          mem_wdata = (kind_in_q == KIND_BAD) ? KIND_AIR : kind_in_q;
        end
      end
      ST_PROBE: begin
        mem_addr = tgt_addr;
        if (tgt_ok) begin
          mem_ctl.en = 1'b1;
        end else if (last_cand) begin
          finish = 1'b1;
        end else begin
          cand_step = 1'b1;
        end
      end
      ST_TEST: begin
        mem_addr = tgt_addr;
        if (mem_rdata == KIND_AIR) begin
          mem_ctl   = '{en: 1'b1, we: 1'b1};
          mem_wdata = kind_q;
        end else if (last_cand) begin
          finish = 1'b1;
        end else begin
          cand_step = 1'b1;
        end
      end
      ST_VACATE: begin
        mem_ctl  = '{en: 1'b1, we: 1'b1};
        finish   = 1'b1;
        fin_move = move_q;
      end
      default: begin
        finish = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WIPE;
      wipe_addr <= '0;
      cand_idx  <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (state == ST_WIPE) wipe_addr <= wipe_addr + ADDR_W'(1);
      if (state == ST_SRC) begin
        cand_idx <= '0;
      end else if (cand_step) begin
        cand_idx <= cand_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      cmd_q     <= cmd;
      col_q     <= col;
      row_q     <= row;
      kind_in_q <= kind_in;
      diag_q    <= rand_diag;
      side_q    <= rand_side;
    end
    if (state == ST_SRC) kind_q <= mem_rdata;
    if ((state == ST_TEST) && (mem_rdata == KIND_AIR)) move_q <= cand_m;
    if (finish) begin
      kind_out  <= fin_kind;
      move_done <= fin_move;
    end
  end

  `FSC_ASSERT_PROP(a_done_one_cycle, clk, rst, done |=> !done, "done held for two cycles")
  `FSC_ASSERT_PROP(a_done_after_work, clk, rst, done |-> $past(state) != ST_IDLE,
                   "result without a command in flight")
  `FSC_ASSERT_NEVER(a_no_idle_write, clk, rst, (state == ST_IDLE) && mem_ctl.we,
                    "grid written while idle")
  `FSC_ASSERT_PROP(a_move_needs_grain, clk, rst,
                   (done && (move_done != MOVE_NONE)) |->
                   (kind_out == KIND_SAND || kind_out == KIND_WATER),
                   "move reported for a cell that held no grain")
  `FSC_ASSERT_NEVER(a_cand_range, clk, rst, cand_idx > CAND_LAST_WATER,
                    "candidate index out of range")

endmodule

`default_nettype wire

@@ src/falling_sand_cell_update.sv @@
// Read, write and out-of-range commands finish after the source access (ST_SRC);
// an update steps through the grid memory accesses in order: source read, then
// per candidate a probe read and a test (skipped for a target outside the grid), plus a vacate of the source on a move.
// A new command is accepted in the cycle its predecessor's result is shown.
// Reset: a clearing pass writes air to all MAX_COLS*MAX_ROWS cells, one per cycle, with
// busy high; configuration writes are taken throughout. The receiver cannot stall.
// ---------------------------------------------------------------------------
// Falling-sand cell update: top level
// Configuration registers, command sequencer and grid memory.
// ---------------------------------------------------------------------------
`default_nettype none

module falling_sand_cell_update import fsc_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       cmd,
  input  wire logic [7:0]       col,
  input  wire logic [7:0]       row,
  input  wire logic [1:0]       kind_in,
  input  wire logic             rand_diag,
  input  wire logic             rand_side,
  output logic                  done,
  output logic      [1:0]       kind_out,
  output logic      [2:0]       move_done,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [CFG_W-1:0]  grid_width, grid_height;
  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] mem_addr;
  logic [1:0]        mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= CFG_DIM_RESET;
      grid_height <= CFG_DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  grid_width  <= cfg_data;
        CFG_IDX_HEIGHT: grid_height <= cfg_data;
        default:        grid_width  <= grid_width;
      endcase
    end
  end

  fsc_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .DEPTH    (DEPTH),
    .ADDR_W   (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .col         (col),
    .row         (row),
    .kind_in     (kind_in),
    .rand_diag   (rand_diag),
    .rand_side   (rand_side),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .busy        (busy),
    .done        (done),
    .kind_out    (kind_out),
    .move_done   (move_done),
    .mem_ctl     (mem_ctl),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata)
  );

  fsc_grid_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_grid (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// ---------------------------------------------------------------------------
// Falling-sand cell update: testbench
// Drives write, update and read commands through the start/busy handshake,
// changes the grid size between phases and checks every result against a
// typed expectation or a cycle-free model of the grid kept inside the bench.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fsc_pkg::*;

  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int GRID_CELLS = DEF_MAX_COLS * DEF_MAX_ROWS;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int STEADY_FIRST = 1000;
  localparam int STEADY_LAST = 1200;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] col;
    logic [7:0] row;
    logic [1:0] kind;
    logic       diag_left;
    logic       side_left;
  } cell_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] move;
  } cell_result_t;

  typedef struct packed {
    cell_cmd_t    txn;
    logic         typed;
    cell_result_t want;
  } directed_row_t;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic [15:0]      count;
    logic [7:0]       col_lo;
    logic [7:0]       col_hi;
    logic [7:0]       row_lo;
    logic [7:0]       row_hi;
    logic [7:0]       wide_pct;
  } grid_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] cmd = CMD_READ;
  logic [7:0] col = 8'd0;
  logic [7:0] row = 8'd0;
  logic [1:0] kind_in = KIND_AIR;
  logic rand_diag = 1'b0;
  logic rand_side = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_index = CFG_IDX_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic busy;
  logic done;
  logic [1:0] kind_out;
  logic [2:0] move_done;
  logic cfg_ready;

  falling_sand_cell_update DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .col(col), .row(row),
    .kind_in(kind_in), .rand_diag(rand_diag), .rand_side(rand_side), .done(done),
    .kind_out(kind_out), .move_done(move_done), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the grid and of the size registers.
  logic [1:0] grid_shadow [0:GRID_CELLS-1];
  logic [CFG_W-1:0] width_reg = CFG_DIM_RESET;
  logic [CFG_W-1:0] height_reg = CFG_DIM_RESET;
  cell_result_t pending_results [$];
  int fail_count = 0;
  int accepted_cmds = 0;
  int stall_cycles = 0;

  // Left to right: op, col, row, kind, diag, side, then typed expectation if any.
  directed_row_t directed [0:24] = '{
    '{'{CMD_READ,   8'd0,   8'd0,   KIND_AIR,   1'b0, 1'b0}, 1'b1, '{KIND_AIR, MOVE_NONE}},
    '{'{CMD_READ,   8'd255, 8'd255, KIND_AIR,   1'b1, 1'b1}, 1'b1, '{KIND_AIR, MOVE_NONE}},
    '{'{CMD_WRITE,  8'd255, 8'd255, KIND_WATER, 1'b0, 1'b0}, 1'b1, '{KIND_AIR, MOVE_NONE}},
    '{'{CMD_READ,   8'd199, 8'd199, KIND_AIR,   1'b0, 1'b0}, 1'b1, '{KIND_AIR, MOVE_NONE}},
    '{'{CMD_WRITE,  8'd199, 8'd199, KIND_SAND,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'd199, 8'd199, KIND_AIR,   1'b1, 1'b1}, 1'b0, '0},
    '{'{CMD_WRITE,  8'd0,   8'd0,   KIND_BAD,   1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_SPARE,  8'd0,   8'd0,   KIND_WATER, 1'b1, 1'b0}, 1'b1, '{KIND_AIR, MOVE_NONE}},
    '{'{CMD_UPDATE, 8'd100, 8'd100, KIND_SAND,  1'b1, 1'b1}, 1'b1, '{KIND_AIR, MOVE_NONE}},
    '{'{CMD_WRITE,  8'd5,   8'd10,  KIND_SAND,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'd5,   8'd10,  KIND_AIR,   1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE,  8'd5,   8'd12,  KIND_SAND,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'd5,   8'd11,  KIND_AIR,   1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE,  8'd5,   8'd11,  KIND_SAND,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'd5,   8'd11,  KIND_AIR,   1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE,  8'd5,   8'd11,  KIND_WATER, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'd5,   8'd11,  KIND_AIR,   1'b1, 1'b1}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'd4,   8'd11,  KIND_AIR,   1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE,  8'd0,   8'd198, KIND_WATER, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE,  8'd0,   8'd199, KIND_SAND,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE,  8'd1,   8'd199, KIND_SAND,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'd0,   8'd198, KIND_AIR,   1'b1, 1'b1}, 1'b0, '0},
    '{'{CMD_WRITE,  8'd199, 8'd198, KIND_SAND,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'd199, 8'd198, KIND_AIR,   1'b0, 1'b1}, 1'b0, '0},
    '{'{CMD_READ,   8'd198, 8'd199, KIND_AIR,   1'b0, 1'b0}, 1'b0, '0}
  };

  // Grid sizes for the random part; the windows crowd grains so they collide.
  grid_phase_t grid_phases [0:7] = '{
    '{9'd8,   9'd6,   16'd350, 8'd0,   8'd9,   8'd0,   8'd7,   8'd0},
    '{9'd1,   9'd4,   16'd100, 8'd0,   8'd1,   8'd0,   8'd5,   8'd0},
    '{9'd256, 9'd256, 16'd300, 8'd248, 8'd255, 8'd248, 8'd255, 8'd25},
    '{9'd0,   9'd0,   16'd50,  8'd0,   8'd3,   8'd0,   8'd3,   8'd20},
    '{9'd511, 9'd2,   16'd150, 8'd0,   8'd5,   8'd0,   8'd2,   8'd10},
    '{9'd5,   9'd511, 16'd200, 8'd0,   8'd6,   8'd250, 8'd255, 8'd0},
    '{9'd256, 9'd1,   16'd50,  8'd250, 8'd255, 8'd0,   8'd1,   8'd0},
    '{9'd16,  9'd16,  16'd350, 8'd0,   8'd17,  8'd0,   8'd17,  8'd0}
  };

  function automatic int cols_used();
    return (width_reg < DEF_MAX_COLS) ? int'(width_reg) : DEF_MAX_COLS;
  endfunction

  function automatic int rows_used();
    return (height_reg < DEF_MAX_ROWS) ? int'(height_reg) : DEF_MAX_ROWS;
  endfunction

  // Moves the grain at (c,r) by (dc,dr) when the target is inside the grid and empty.
  function automatic bit shift_grain(int c, int r, int dc, int dr, logic [1:0] k);
    int tc;
    int tr;
    tc = c + dc;
    tr = r + dr;
    if (tc < 0 || tr < 0 || tc >= cols_used() || tr >= rows_used()) return 1'b0;
    if (grid_shadow[tr * DEF_MAX_COLS + tc] != KIND_AIR) return 1'b0;
    grid_shadow[tr * DEF_MAX_COLS + tc] = k;
    grid_shadow[r * DEF_MAX_COLS + c] = KIND_AIR;
    return 1'b1;
  endfunction

  function automatic logic [2:0] settle_grain(int c, int r, logic [1:0] k, logic dl,
                                              logic sl);
    if (k != KIND_SAND && k != KIND_WATER) return MOVE_NONE;
    if (r + 1 >= rows_used()) return MOVE_NONE;
    if (shift_grain(c, r, 0, 1, k)) return MOVE_DOWN;
    if (dl) begin
      if (shift_grain(c, r, -1, 1, k)) return MOVE_DOWN_LEFT;
      if (shift_grain(c, r, 1, 1, k)) return MOVE_DOWN_RIGHT;
    end else begin
      if (shift_grain(c, r, 1, 1, k)) return MOVE_DOWN_RIGHT;
      if (shift_grain(c, r, -1, 1, k)) return MOVE_DOWN_LEFT;
    end
    if (k != KIND_WATER) return MOVE_NONE;
    if (sl) begin
      if (shift_grain(c, r, -1, 0, k)) return MOVE_LEFT;
      if (shift_grain(c, r, 1, 0, k)) return MOVE_RIGHT;
    end else begin
      if (shift_grain(c, r, 1, 0, k)) return MOVE_RIGHT;
      if (shift_grain(c, r, -1, 0, k)) return MOVE_LEFT;
    end
    return MOVE_NONE;
  endfunction

  function automatic cell_result_t predict_cell_result(cell_cmd_t t);
    cell_result_t res;
    int addr;
    res.kind = KIND_AIR;
    res.move = MOVE_NONE;
    if (int'(t.col) < cols_used() && int'(t.row) < rows_used()) begin
      addr = int'(t.row) * DEF_MAX_COLS + int'(t.col);
      res.kind = grid_shadow[addr];
      if (t.op == CMD_WRITE) begin
        grid_shadow[addr] = (t.kind == KIND_BAD) ? KIND_AIR : t.kind;
      end else if (t.op == CMD_UPDATE) begin
        res.move = settle_grain(int'(t.col), int'(t.row), res.kind, t.diag_left,
                                t.side_left);
      end
    end
    return res;
  endfunction

  // Drives one command and records its expected result once it is taken.
  task automatic issue(cell_cmd_t t, bit typed, cell_result_t want);
    bit steady;
    steady = accepted_cmds >= STEADY_FIRST && accepted_cmds < STEADY_LAST;
    if (!steady && $urandom_range(99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= t.op;
    col <= t.col;
    row <= t.row;
    kind_in <= t.kind;
    rand_diag <= t.diag_left;
    rand_side <= t.side_left;
    do @(posedge clk); while (busy);
    if (typed) begin
      void'(predict_cell_result(t));
      pending_results.push_back(want);
    end else begin
      pending_results.push_back(predict_cell_result(t));
    end
    accepted_cmds++;
  endtask

  // Both size registers go out back to back with valid held high.
  task automatic set_grid_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_WIDTH;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    width_reg = w;
    cfg_index <= CFG_IDX_HEIGHT;
    cfg_data <= h;
    do @(posedge clk); while (!cfg_ready);
    height_reg = h;
    cfg_valid <= 1'b0;
  endtask

  function automatic cell_cmd_t random_cmd(grid_phase_t p);
    cell_cmd_t t;
    int pick;
    pick = $urandom_range(99);
    t.op = (pick < 35) ? CMD_WRITE : (pick < 80) ? CMD_UPDATE :
           (pick < 95) ? CMD_READ : CMD_SPARE;
    pick = $urandom_range(9);
    t.kind = (pick < 4) ? KIND_SAND : (pick < 7) ? KIND_WATER :
             (pick < 9) ? KIND_AIR : KIND_BAD;
    if ($urandom_range(99) < p.wide_pct) begin
      t.col = 8'($urandom_range(255));
      t.row = 8'($urandom_range(255));
    end else begin
      t.col = 8'($urandom_range(p.col_hi, p.col_lo));
      t.row = 8'($urandom_range(p.row_hi, p.row_lo));
    end
    t.diag_left = 1'($urandom_range(1));
    t.side_left = 1'($urandom_range(1));
    return t;
  endfunction

  initial begin
    for (int i = 0; i < GRID_CELLS; i++) grid_shadow[i] = KIND_AIR;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) issue(directed[i].txn, directed[i].typed, directed[i].want);
    start <= 1'b0;

    foreach (grid_phases[p]) begin
      while (pending_results.size() != 0) @(posedge clk);
      set_grid_size(grid_phases[p].width, grid_phases[p].height);
      for (int n = 0; n < int'(grid_phases[p].count); n++) begin
        issue(random_cmd(grid_phases[p]), 1'b0, '0);
      end
      start <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Results are sampled at the edge that ends the cycle they are shown in.
  always @(posedge clk) begin
    cell_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none outstanding, kind_out %0d move_done %0d", $time,
                 kind_out, move_done);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (kind_out !== want.kind) begin
          $display("%0t: kind_out expected %0d actual %0d", $time, want.kind, kind_out);
          fail_count++;
        end
        if (move_done !== want.move) begin
          $display("%0t: move_done expected %0d actual %0d", $time, want.move, move_done);
          fail_count++;
        end
      end
    end
  end

  // Any accepted transaction, on either channel or at the output, resets the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
